// File: rtl/ezht_pkg.sv
`default_nettype none
package ezht_pkg;

   // Width of the CORDIC datapath (Q1.30 with headroom, and the phase).
   localparam int DATA_W = 34;
   localparam int STAGE_MAX = 24;
   localparam int PROD_W = 30;
   localparam int TRIPLE_W = 47;

   // Start value of x: the gain-compensated 1.0 in Q1.30.
   localparam logic signed [DATA_W-1:0] CORDIC_X0 = 34'sd652032874;
   localparam logic signed [17:0] UNIT_POS = 18'sd16384;
   localparam logic signed [17:0] UNIT_NEG = -18'sd16384;

   // One angle in flight through the CORDIC row.
   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
      logic flip;
   } lane_type;

   // What one cell hands to the next.
   typedef struct packed {
      lane_type yaw;
      lane_type pitch;
      lane_type roll;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
   } cell_word_type;

   // Arctangent steps, 2^32 per turn.
   function automatic logic [31:0] atan_step(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0: r = 32'h20000000;
         5'd1: r = 32'h12E4051E;
         5'd2: r = 32'h09FB385B;
         5'd3: r = 32'h051111D4;
         5'd4: r = 32'h028B0D43;
         5'd5: r = 32'h0145D7E1;
         5'd6: r = 32'h00A2F61E;
         5'd7: r = 32'h00517C55;
         5'd8: r = 32'h0028BE53;
         5'd9: r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   // Clamp an 18 bit value to the unit range of Q1.14.
   function automatic logic signed [15:0] clamp_unit(input logic signed [17:0] v);
      logic signed [17:0] r;
      if (v > UNIT_POS) begin
         r = UNIT_POS;
      end else if (v < UNIT_NEG) begin
         r = UNIT_NEG;
      end else begin
         r = v;
      end
      return r[15:0];
   endfunction

   // Round a CORDIC output in Q1.30 to Q1.14.
   function automatic logic signed [15:0] round_trig(input logic signed [DATA_W-1:0] v);
      logic signed [DATA_W-1:0] s;
      s = (v + 34'sd32768) >>> 16;
      return clamp_unit(s[17:0]);
   endfunction

   // Round a two-factor product in Q2.28 to Q1.14.
   function automatic logic signed [15:0] round_pair(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] s;
      s = (v + 30'sd8192) >>> 14;
      return clamp_unit(s[17:0]);
   endfunction

   // Round a three-factor sum in Q3.42 to Q1.14.
   function automatic logic signed [15:0] round_triple(input logic signed [TRIPLE_W-1:0] v);
      logic signed [TRIPLE_W-1:0] s;
      s = (v + 47'sd134217728) >>> 28;
      return clamp_unit(s[17:0]);
   endfunction

endpackage
`default_nettype wire

// File: rtl/euler_zyx_to_homogeneous_transform_top.sv
`default_nettype none
// ZYX Euler pose to homogeneous transform. Each word carries a Q16.16 position
// and yaw, pitch and roll as 16 bit binary angles; the result word holds the
// top three rows of the transform, rotation entries in Q1.14 and the position
// copied into the last column. A new word is taken every cycle unless the
// output stalls. Each word passes the CORDIC row, one cell per angle bit up
// to STAGE_MAX, which rotates all three angles side by side, then rounding,
// two multiplier stages and the final sum and saturation feeding the outputs.
module euler_zyx_to_homogeneous_transform_top
   import ezht_pkg::*;
#(
   parameter int ANGLE_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic signed [31:0] req_pos_x,
   input wire logic signed [31:0] req_pos_y,
   input wire logic signed [31:0] req_pos_z,
   input wire logic signed [15:0] req_yaw_angle,
   input wire logic signed [15:0] req_pitch_angle,
   input wire logic signed [15:0] req_roll_angle,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic signed [15:0] rsp_m00,
   output logic signed [15:0] rsp_m01,
   output logic signed [15:0] rsp_m02,
   output logic signed [31:0] rsp_trans_x,
   output logic signed [15:0] rsp_m10,
   output logic signed [15:0] rsp_m11,
   output logic signed [15:0] rsp_m12,
   output logic signed [31:0] rsp_trans_y,
   output logic signed [15:0] rsp_m20,
   output logic signed [15:0] rsp_m21,
   output logic signed [15:0] rsp_m22,
   output logic signed [31:0] rsp_trans_z
);

   localparam int STAGES = (ANGLE_BITS < 1) ? 1 :
                           (ANGLE_BITS > STAGE_MAX) ? STAGE_MAX : ANGLE_BITS;
   localparam logic [31:0] KEEP_MASK = ~(32'hFFFFFFFF >> STAGES);

   logic [STAGES:0] chain_valid;
   logic [STAGES:0] chain_ready;
   cell_word_type chain_word [STAGES+1];
   logic [31:0] trans_x, trans_y, trans_z;

   // Fold an angle into the right half plane; the flip undoes it later.
   function automatic lane_type prep(input logic [15:0] ang);
      lane_type r;
      logic [31:0] ph;
      ph = {ang, 16'h0000} & KEEP_MASK;
      r.flip = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
      if (r.flip) begin
         ph[31] = ~ph[31];
      end
      r.x = CORDIC_X0;
      r.y = '0;
      r.z = DATA_W'(signed'(ph));
      return r;
   endfunction

   always_comb begin
      chain_word[0].yaw = prep(req_yaw_angle);
      chain_word[0].pitch = prep(req_pitch_angle);
      chain_word[0].roll = prep(req_roll_angle);
      chain_word[0].pos_x = req_pos_x;
      chain_word[0].pos_y = req_pos_y;
      chain_word[0].pos_z = req_pos_z;
   end

   assign chain_valid[0] = req_valid;
   assign req_ready = chain_ready[0];

   // The CORDIC row, one micro-rotation per cell.
   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      ezht_cordic_cell #(.STAGE(i)) u_cell (
         .clock(clock),
         .reset(reset),
         .in_valid(chain_valid[i]),
         .in_ready(chain_ready[i]),
         .in_word(chain_word[i]),
         .out_valid(chain_valid[i+1]),
         .out_ready(chain_ready[i+1]),
         .out_word(chain_word[i+1])
      );
   end

   ezht_matrix u_matrix (
      .clock(clock),
      .reset(reset),
      .in_valid(chain_valid[STAGES]),
      .in_ready(chain_ready[STAGES]),
      .in_word(chain_word[STAGES]),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .m00(rsp_m00),
      .m01(rsp_m01),
      .m02(rsp_m02),
      .m10(rsp_m10),
      .m11(rsp_m11),
      .m12(rsp_m12),
      .m20(rsp_m20),
      .m21(rsp_m21),
      .m22(rsp_m22),
      .trans_x(trans_x),
      .trans_y(trans_y),
      .trans_z(trans_z)
   );

   assign rsp_trans_x = signed'(trans_x);
   assign rsp_trans_y = signed'(trans_y);
   assign rsp_trans_z = signed'(trans_z);

   // Saturation keeps every rotation entry within the unit range.
   a_m01_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_m01 <= 16'sd16384) && (rsp_m01 >= -16'sd16384))
      else $error("m01 out of unit range");

   a_m12_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_m12 <= 16'sd16384) && (rsp_m12 >= -16'sd16384))
      else $error("m12 out of unit range");

   // Nothing comes out in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present after reset");

endmodule
`default_nettype wire

// File: rtl/ezht_cordic_cell.sv
`default_nettype none
module ezht_cordic_cell
   import ezht_pkg::*;
#(
   parameter int STAGE = 0
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire cell_word_type in_word,
   output logic out_valid,
   input wire logic out_ready,
   output cell_word_type out_word
);

   logic valid_ff;
   cell_word_type word_ff;
   cell_word_type word_in;
   logic signed [DATA_W-1:0] step;

   assign step = DATA_W'(signed'({1'b0, atan_step(5'(STAGE))}));

   // One micro-rotation on a single lane.
   function automatic lane_type rotate(input lane_type a, input logic signed [DATA_W-1:0] st);
      lane_type r;
      logic signed [DATA_W-1:0] dx;
      logic signed [DATA_W-1:0] dy;
      dx = a.y >>> STAGE;
      dy = a.x >>> STAGE;
      r.flip = a.flip;
      if (a.z >= 0) begin
         r.x = a.x - dx;
         r.y = a.y + dy;
         r.z = a.z - st;
      end else begin
         r.x = a.x + dx;
         r.y = a.y - dy;
         r.z = a.z + st;
      end
      return r;
   endfunction

   always_comb begin
      word_in = in_word;
      word_in.yaw = rotate(in_word.yaw, step);
      word_in.pitch = rotate(in_word.pitch, step);
      word_in.roll = rotate(in_word.roll, step);
   end

   assign in_ready = !valid_ff || out_ready;

   // The stage moves whenever it is empty or its word is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word = word_ff;

endmodule
`default_nettype wire

// File: rtl/ezht_matrix.sv
`default_nettype none
module ezht_matrix
   import ezht_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire cell_word_type in_word,
   output logic out_valid,
   input wire logic out_ready,
   output logic signed [15:0] m00,
   output logic signed [15:0] m01,
   output logic signed [15:0] m02,
   output logic signed [15:0] m10,
   output logic signed [15:0] m11,
   output logic signed [15:0] m12,
   output logic signed [15:0] m20,
   output logic signed [15:0] m21,
   output logic signed [15:0] m22,
   output logic [31:0] trans_x,
   output logic [31:0] trans_y,
   output logic [31:0] trans_z
);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic go1, go2, go3, go4;

   logic signed [15:0] cy_ff, sy_ff, cp_ff, sp_ff, cr_ff, sr_ff;
   logic [31:0] px1_ff, py1_ff, pz1_ff;
   logic signed [15:0] cy2_ff, sy2_ff, sp2_ff;
   logic signed [PROD_W-1:0] spsr_ff, spcr_ff, cycp_ff, sycp_ff, cycr_ff, sysr_ff;
   logic signed [PROD_W-1:0] sycr_ff, cysr_ff, cpsr_ff, cpcr_ff;
   logic [31:0] px2_ff, py2_ff, pz2_ff;
   logic signed [TRIPLE_W-1:0] t1_ff, t2_ff, t3_ff, t4_ff;
   logic signed [PROD_W-1:0] cycp3_ff, sycp3_ff, cycr3_ff, sysr3_ff;
   logic signed [PROD_W-1:0] sycr3_ff, cysr3_ff, cpsr3_ff, cpcr3_ff;
   logic signed [15:0] sp3_ff;
   logic [31:0] px3_ff, py3_ff, pz3_ff;
   logic signed [TRIPLE_W-1:0] e01, e02, e11, e12;
   logic signed [17:0] neg_sp;

   // Backpressure through the four stages.
   assign go4 = !v4_ff || out_ready;
   assign go3 = !v3_ff || go4;
   assign go2 = !v2_ff || go3;
   assign go1 = !v1_ff || go2;
   assign in_ready = go1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (go1) v1_ff <= in_valid;
         if (go2) v2_ff <= v1_ff;
         if (go3) v3_ff <= v2_ff;
         if (go4) v4_ff <= v3_ff;
      end
   end

   // Stage one: undo the quadrant fold, round sine and cosine to Q1.14.
   always_ff @(posedge clock) begin
      if (go1 && in_valid) begin
         cy_ff <= round_trig(in_word.yaw.flip ? -in_word.yaw.x : in_word.yaw.x);
         sy_ff <= round_trig(in_word.yaw.flip ? -in_word.yaw.y : in_word.yaw.y);
         cp_ff <= round_trig(in_word.pitch.flip ? -in_word.pitch.x : in_word.pitch.x);
         sp_ff <= round_trig(in_word.pitch.flip ? -in_word.pitch.y : in_word.pitch.y);
         cr_ff <= round_trig(in_word.roll.flip ? -in_word.roll.x : in_word.roll.x);
         sr_ff <= round_trig(in_word.roll.flip ? -in_word.roll.y : in_word.roll.y);
         px1_ff <= in_word.pos_x;
         py1_ff <= in_word.pos_y;
         pz1_ff <= in_word.pos_z;
      end
   end

   // Stage two: all two-factor products.
   always_ff @(posedge clock) begin
      if (go2 && v1_ff) begin
         spsr_ff <= PROD_W'(sp_ff * sr_ff);
         spcr_ff <= PROD_W'(sp_ff * cr_ff);
         cycp_ff <= PROD_W'(cy_ff * cp_ff);
         sycp_ff <= PROD_W'(sy_ff * cp_ff);
         cycr_ff <= PROD_W'(cy_ff * cr_ff);
         sysr_ff <= PROD_W'(sy_ff * sr_ff);
         sycr_ff <= PROD_W'(sy_ff * cr_ff);
         cysr_ff <= PROD_W'(cy_ff * sr_ff);
         cpsr_ff <= PROD_W'(cp_ff * sr_ff);
         cpcr_ff <= PROD_W'(cp_ff * cr_ff);
         cy2_ff <= cy_ff;
         sy2_ff <= sy_ff;
         sp2_ff <= sp_ff;
         px2_ff <= px1_ff;
         py2_ff <= py1_ff;
         pz2_ff <= pz1_ff;
      end
   end

   // Stage three: three-factor products with the yaw terms.
   always_ff @(posedge clock) begin
      if (go3 && v2_ff) begin
         t1_ff <= TRIPLE_W'(cy2_ff * spsr_ff);
         t2_ff <= TRIPLE_W'(cy2_ff * spcr_ff);
         t3_ff <= TRIPLE_W'(sy2_ff * spsr_ff);
         t4_ff <= TRIPLE_W'(sy2_ff * spcr_ff);
         cycp3_ff <= cycp_ff;
         sycp3_ff <= sycp_ff;
         cycr3_ff <= cycr_ff;
         sysr3_ff <= sysr_ff;
         sycr3_ff <= sycr_ff;
         cysr3_ff <= cysr_ff;
         cpsr3_ff <= cpsr_ff;
         cpcr3_ff <= cpcr_ff;
         sp3_ff <= sp2_ff;
         px3_ff <= px2_ff;
         py3_ff <= py2_ff;
         pz3_ff <= pz2_ff;
      end
   end

   // Stage four: sums, rounding and saturation into the output register.
   assign e01 = t1_ff - (TRIPLE_W'(sycr3_ff) <<< 14);
   assign e02 = t2_ff + (TRIPLE_W'(sysr3_ff) <<< 14);
   assign e11 = t3_ff + (TRIPLE_W'(cycr3_ff) <<< 14);
   assign e12 = t4_ff - (TRIPLE_W'(cysr3_ff) <<< 14);
   assign neg_sp = -18'(sp3_ff);

   always_ff @(posedge clock) begin
      if (go4 && v3_ff) begin
         m00 <= round_pair(cycp3_ff);
         m01 <= round_triple(e01);
         m02 <= round_triple(e02);
         m10 <= round_pair(sycp3_ff);
         m11 <= round_triple(e11);
         m12 <= round_triple(e12);
         m20 <= clamp_unit(neg_sp);
         m21 <= round_pair(cpsr3_ff);
         m22 <= round_pair(cpcr3_ff);
         trans_x <= px3_ff;
         trans_y <= py3_ff;
         trans_z <= pz3_ff;
      end
   end

   assign out_valid = v4_ff;

endmodule
`default_nettype wire
